>>> hw/rtl/shtr_pkg.sv
package shtr_pkg;

   // fixed field widths
   localparam int RATE_W    = 12;
   localparam int TIME_W    = 20;
   localparam int HEADING_W = 16;
   localparam int ANG_W     = 16;
   localparam int STEP_W    = 15;
   localparam int ERR_W     = 18;

   // angles in 1/128 degree
   localparam int FULL_TURN = 46080;
   localparam int HALF_TURN = 23040;

   // cordic angle accumulator in 2^-16 degree
   localparam int PRE_SCALE = 16;
   localparam int Z_W       = 26;
   localparam logic signed [Z_W-1:0] FINE_HALF_TURN = 26'sd11796480;
   localparam int ROUND_BIAS  = 256;
   localparam int ROUND_SHIFT = 9;

   // arctangent table, 2^-16 degree, rounded to nearest
   localparam int TABLE_LEN = 24;
   localparam int ATAN_W    = 22;
   localparam logic [ATAN_W-1:0] ATAN_FINE [TABLE_LEN] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
      22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
   };

   // turn limit: step = floor(2 * rate * dt / 15625), saturating at a half turn
   localparam int PROD_W     = RATE_W + TIME_W;
   localparam int Q_W        = PROD_W + 1;
   localparam int QS_W       = 29;
   localparam int RECIP_W    = 30;
   localparam int MUL_W      = QS_W + RECIP_W;
   localparam int STEP_SHIFT = 43;
   localparam longint StepDiv = 15625;
   localparam logic [Q_W-1:0] STEP_SAT_LIMIT = Q_W'((HALF_TURN + 1) * StepDiv);
   localparam logic [RECIP_W-1:0] STEP_RECIP =
      RECIP_W'(((64'd1 << STEP_SHIFT) + StepDiv - 1) / StepDiv);

   // register reset values
   localparam int CENTRE_X_RESET  = 400;
   localparam int CENTRE_Y_RESET  = 300;
   localparam int TURN_RATE_RESET = 20;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_RATE = 2'd2;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef struct packed {
      logic signed [ANG_W-1:0] bearing;
      logic [STEP_W-1:0]       step;
   } work_type;

endpackage

>>> hw/rtl/shtr_req_if.sv
interface shtr_req_if
   import shtr_pkg::*;
#(
   parameter int COORD_BITS = 12
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] target_x;
   logic signed [COORD_BITS-1:0] target_y;
   logic [TIME_W-1:0]            elapsed_us;

   modport source (output valid, output target_x, output target_y, output elapsed_us,
                   input ready);
   modport sink (input valid, input target_x, input target_y, input elapsed_us,
                 output ready);
endinterface

>>> hw/rtl/shtr_rsp_if.sv
interface shtr_rsp_if
   import shtr_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [HEADING_W-1:0] new_heading;

   modport source (output valid, output new_heading, input ready);
   modport sink (input valid, input new_heading, output ready);
endinterface

>>> hw/rtl/shtr_front.sv
module shtr_front
   import shtr_pkg::*;
#(
   parameter int CORDIC_STAGES = 16,
   parameter int COORD_BITS    = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   shtr_req_if.sink                     req,
   input  logic signed [COORD_BITS-1:0] centre_x,
   input  logic signed [COORD_BITS-1:0] centre_y,
   input  logic [RATE_W-1:0]            turn_rate,
   input  logic                         q_ready,
   output logic                         q_push,
   output work_type                     q_data
);

   localparam int N    = CORDIC_STAGES;
   localparam int D_W  = COORD_BITS + 1;
   localparam int XY_W = COORD_BITS + PRE_SCALE + 3;

   logic adv;

   // offset stage
   logic                  s0_valid_ff;
   logic signed [D_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [TIME_W-1:0]     dt_ff;

   // cordic pipeline, entry 0 is the pre-rotated vector
   logic [N:0]             cv_ff;
   logic signed [XY_W-1:0] x_ff [N+1];
   logic signed [XY_W-1:0] y_ff [N+1];
   logic signed [Z_W-1:0]  z_ff [N+1];
   logic [N:0]             axis_ff;
   logic [N:0]             axis_neg_ff;
   logic signed [XY_W-1:0] xs_in, ys_in, x0_in, y0_in;
   logic signed [Z_W-1:0]  z0_in;

   // turn limit side path
   logic [PROD_W-1:0] p_ff;
   logic [Q_W-1:0]    qd_in;
   logic              q_sat_ff;
   logic [QS_W-1:0]   qs_ff;
   logic [MUL_W-1:0]  prod_ff;
   logic              prod_sat_ff;
   logic [STEP_W-1:0] step_ff [3:N];

   // rounding stage
   logic                    r_valid_ff;
   logic signed [ANG_W-1:0] bearing_ff, bearing_in;
   logic [STEP_W-1:0]       r_step_ff;
   logic signed [Z_W-1:0]   zsum_in, zr_in;

   // the whole front moves unless its last stage is blocked by a full queue
   assign adv       = !(r_valid_ff && !q_ready);
   assign req.ready = adv;

   assign dx_in = {req.target_x[COORD_BITS-1], req.target_x}
                - {centre_x[COORD_BITS-1], centre_x};
   assign dy_in = {req.target_y[COORD_BITS-1], req.target_y}
                - {centre_y[COORD_BITS-1], centre_y};

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         cv_ff       <= '0;
         r_valid_ff  <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req.valid;
         cv_ff       <= {cv_ff[N-1:0], s0_valid_ff};
         r_valid_ff  <= cv_ff[N];
      end
   end

   // offsets from the pivot
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dt_ff <= req.elapsed_us;
      end
   end

   // scale and fold the left half plane onto the right one
   always_comb begin
      xs_in = {{2{dx_ff[D_W-1]}}, dx_ff, {PRE_SCALE{1'b0}}};
      ys_in = {{2{dy_ff[D_W-1]}}, dy_ff, {PRE_SCALE{1'b0}}};
      if (dx_ff[D_W-1]) begin
         x0_in = -xs_in;
         y0_in = -ys_in;
         z0_in = dy_ff[D_W-1] ? -FINE_HALF_TURN : FINE_HALF_TURN;
      end else begin
         x0_in = xs_in;
         y0_in = ys_in;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]        <= x0_in;
         y_ff[0]        <= y0_in;
         z_ff[0]        <= z0_in;
         axis_ff[0]     <= (dy_ff == '0);
         axis_neg_ff[0] <= dx_ff[D_W-1];
         p_ff           <= PROD_W'(turn_rate) * PROD_W'(dt_ff);
      end
   end

   // vectoring stages
   for (genvar i = 0; i < N; i++) begin : g_cordic
      logic signed [Z_W-1:0]  ang_c;
      logic signed [XY_W-1:0] x_in, y_in;
      logic signed [Z_W-1:0]  z_in;

      assign ang_c = Z_W'(ATAN_FINE[i]);

      always_comb begin
         if (y_ff[i] > 0) begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + ang_c;
         end else begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - ang_c;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i+1]        <= x_in;
            y_ff[i+1]        <= y_in;
            z_ff[i+1]        <= z_in;
            axis_ff[i+1]     <= axis_ff[i];
            axis_neg_ff[i+1] <= axis_neg_ff[i];
         end
      end
   end

   // turn limit: double, saturate check, reciprocal multiply, then carry along
   assign qd_in = {p_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (adv) begin
         q_sat_ff    <= (qd_in >= STEP_SAT_LIMIT);
         qs_ff       <= qd_in[QS_W-1:0];
         prod_sat_ff <= q_sat_ff;
         prod_ff     <= MUL_W'(qs_ff) * MUL_W'(STEP_RECIP);
         step_ff[3]  <= prod_sat_ff ? STEP_W'(HALF_TURN)
                                    : prod_ff[STEP_SHIFT+STEP_W-1:STEP_SHIFT];
      end
   end

   for (genvar j = 4; j <= N; j++) begin : g_step_delay
      always_ff @(posedge clock) begin
         if (adv) begin
            step_ff[j] <= step_ff[j-1];
         end
      end
   end

   // round to 1/128 degree, clamp, axis cases
   always_comb begin
      zsum_in = z_ff[N] + Z_W'(ROUND_BIAS);
      zr_in   = zsum_in >>> ROUND_SHIFT;
      if (axis_ff[N]) begin
         bearing_in = axis_neg_ff[N] ? ANG_W'(HALF_TURN) : '0;
      end else if (zr_in > HALF_TURN) begin
         bearing_in = ANG_W'(HALF_TURN);
      end else if (zr_in < -HALF_TURN) begin
         bearing_in = ANG_W'(-HALF_TURN);
      end else begin
         bearing_in = zr_in[ANG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bearing_ff <= bearing_in;
         r_step_ff  <= step_ff[N];
      end
   end

   assign q_push = r_valid_ff && q_ready;
   assign q_data = '{bearing: bearing_ff, step: r_step_ff};

endmodule

>>> hw/rtl/shtr_queue.sv
module shtr_queue
   import shtr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     push_ready,
   input  logic     pop,
   output logic     pop_valid,
   output work_type pop_data
);

   work_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, rd_ff;
   logic [QPTR_W:0]     count_ff;

   assign push_ready = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/shtr_back.sv
module shtr_back
   import shtr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  work_type  q_data,
   output logic      q_pop,
   shtr_rsp_if.source rsp
);

   logic                    rsp_valid_ff;
   logic [HEADING_W-1:0]    heading_ff, heading_in;
   logic                    take;
   logic signed [ERR_W-1:0] head_x, bear_x, step_x, err_raw, err_w, nh_raw, nh_w;

   // take the next item whenever the output register is free or emptying
   assign take  = q_valid && (!rsp_valid_ff || rsp.ready);
   assign q_pop = take;

   // wrap error, limit the turn, reduce into one turn
   always_comb begin
      head_x  = ERR_W'(heading_ff);
      bear_x  = ERR_W'(q_data.bearing);
      step_x  = ERR_W'(q_data.step);
      err_raw = bear_x - head_x;
      if (err_raw > HALF_TURN) begin
         err_w = err_raw - ERR_W'(FULL_TURN);
      end else if (err_raw < -HALF_TURN) begin
         err_w = err_raw + ERR_W'(FULL_TURN);
      end else begin
         err_w = err_raw;
      end
      if (err_w > step_x) begin
         nh_raw = head_x + step_x;
      end else if (err_w < -step_x) begin
         nh_raw = head_x - step_x;
      end else begin
         nh_raw = head_x + err_w;
      end
      if (nh_raw < 0) begin
         nh_w = nh_raw + ERR_W'(FULL_TURN);
      end else if (nh_raw >= FULL_TURN) begin
         nh_w = nh_raw - ERR_W'(FULL_TURN);
      end else begin
         nh_w = nh_raw;
      end
      heading_in = nh_w[HEADING_W-1:0];
   end

   // heading state doubles as the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         heading_ff   <= heading_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.new_heading = heading_ff;

endmodule

>>> hw/rtl/slew_limited_heading_tracker_top.sv
// Slew-limited heading tracker. Each item carries a target point and the
// microseconds since the previous item; the block takes the bearing from the
// pivot to the target with a pipelined CORDIC atan2 (zero vector gives 0),
// turns the stored heading toward it by at most turn_rate * elapsed time
// (capped at 180 degrees) and returns the new heading in 1/128 degree,
// 0..46079. One item is accepted per cycle and one result leaves per cycle,
// sustained while rsp_chan is ready. The front (offset, pre-rotation,
// CORDIC_STAGES vectoring stages, rounding) is a feed-forward pipeline; the
// heading update is a single-register loop in the back, and a four-entry
// queue between them lets each side stall alone. Registers: index 0
// centre_x, 1 centre_y, 2 turn_rate; write them only while no item is
// in flight.
module slew_limited_heading_tracker_top
   import shtr_pkg::*;
#(
   parameter int CORDIC_STAGES = 16,
   parameter int COORD_BITS    = 12,
   localparam int CSR_W = (COORD_BITS > RATE_W) ? COORD_BITS : RATE_W
) (
   input  logic                 clock,
   input  logic                 reset,
   shtr_req_if.sink             req_chan,
   shtr_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic signed [COORD_BITS-1:0] centre_x_ff, centre_y_ff;
   logic [RATE_W-1:0]            turn_rate_ff;

   logic     q_push, q_ready, q_pop, q_valid;
   work_type q_in_data, q_out_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff  <= COORD_BITS'(CENTRE_X_RESET);
         centre_y_ff  <= COORD_BITS'(CENTRE_Y_RESET);
         turn_rate_ff <= RATE_W'(TURN_RATE_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTRE_X: begin
               centre_x_ff <= csr_wdata[COORD_BITS-1:0];
            end
            CSR_CENTRE_Y: begin
               centre_y_ff <= csr_wdata[COORD_BITS-1:0];
            end
            CSR_TURN_RATE: begin
               turn_rate_ff <= csr_wdata[RATE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // bearing and turn limit pipeline
   shtr_front #(
      .CORDIC_STAGES (CORDIC_STAGES),
      .COORD_BITS    (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .centre_x  (centre_x_ff),
      .centre_y  (centre_y_ff),
      .turn_rate (turn_rate_ff),
      .q_ready   (q_ready),
      .q_push    (q_push),
      .q_data    (q_in_data)
   );

   // decoupling queue
   shtr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in_data),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_out_data)
   );

   // heading update and output register
   shtr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (q_out_data),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule

>>> hw/rtl/shtr_checker.sv
module shtr_checker
   import shtr_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [HEADING_W-1:0] new_heading
);

   // a stalled item holds its heading
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(new_heading))
      else $error("result item changed while stalled");

   // heading stays inside one turn
   a_heading_range: assert property (@(posedge clock)
      rsp_valid |-> (new_heading < HEADING_W'(FULL_TURN)))
      else $error("heading outside 0..46079");

   // reset empties the output side
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item valid right after reset");

   // reset empties the front, so it is ready at once
   a_req_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("not ready right after reset");

endmodule

bind slew_limited_heading_tracker_top shtr_checker u_shtr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .new_heading (rsp_chan.new_heading)
);
